FILE: hdl/dmx512_slot_receiver_assert.svh
// assertion macros used by the dmx slot receiver checker
`ifndef DMX512_SLOT_RECEIVER_ASSERT_SVH
`define DMX512_SLOT_RECEIVER_ASSERT_SVH

// implication checked on every clock edge outside reset
`define DMX_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// implication whose consequence is checked in the following clock cycle
`define DMX_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/dmx_rx_pkg.sv
// shared types and constants of the dmx slot receiver
`default_nettype none

package dmx_rx_pkg;

    // number of consecutive slots captured per frame
    localparam int NUM_CHANNELS = 8;

    localparam int ADDR_W = 9;
    localparam int CNT_W  = 10;
    localparam int BYTE_W = 8;

    // one received character
    typedef struct packed {
        logic              break_seen;
        logic [BYTE_W-1:0] data_byte;
    } char_t;

    // one result item
    typedef struct packed {
        logic              capture_valid;
        logic [ADDR_W-1:0] channel_index;
        logic [BYTE_W-1:0] channel_value;
        logic              frame_done;
        logic              activity;
    } slot_t;

    // handshake between the pipeline stages
    typedef struct packed {
        logic valid;
        logic advance;
    } stage_ctrl_t;

endpackage

`default_nettype wire

FILE: hdl/dmx_rx_if.sv
// item channels of the dmx slot receiver
`default_nettype none

// received character channel
interface dmx_rx_char_if;
    logic       valid;
    logic       ready;
    logic       break_seen;
    logic [7:0] data_byte;

    modport source (output valid, output break_seen, output data_byte, input ready);
    modport sink (input valid, input break_seen, input data_byte, output ready);
endinterface

// captured slot channel
interface dmx_rx_slot_if;
    logic       valid;
    logic       ready;
    logic       capture_valid;
    logic [8:0] channel_index;
    logic [7:0] channel_value;
    logic       frame_done;
    logic       activity;

    modport source (output valid, output capture_valid, output channel_index,
                    output channel_value, output frame_done, output activity,
                    input ready);
    modport sink (input valid, input capture_valid, input channel_index,
                  input channel_value, input frame_done, input activity,
                  output ready);
endinterface

`default_nettype wire

FILE: hdl/dmx512_slot_receiver.sv
// top level of the dmx slot receiver
//
// rx carries one received uart character per item: break_seen (framing
// error, a dmx break) and data_byte. slot carries exactly one result item
// per character: capture_valid, channel_index, channel_value, frame_done
// and activity. cfg_we / cfg_wdata write start_address, the dmx slot number
// of the first captured channel; write it only while no item is in flight.
// A character accepted on rx is held in the input register, then its result
// is loaded into the result register and shows on slot (two register stages).
// Throughput: one item per cycle while slot.ready is high; the frame state is
// updated by short logic between the two registers; items flow without gaps.
// When slot.ready is low the result register holds its item, the input
// register fills, and rx.ready drops until slot drains; nothing is lost.
// Reset (rst_n low, asynchronous) empties both stages, returns the frame
// state to idle with the slot counter at zero and sets start_address to 1.
`default_nettype none

module dmx512_slot_receiver (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_we,
    input  wire logic [8:0] cfg_wdata,
    dmx_rx_char_if.sink     rx,
    dmx_rx_slot_if.source   slot
);
    import dmx_rx_pkg::*;

    char_t       in_item;
    char_t       held_item;
    slot_t       result;
    slot_t       out_item;
    stage_ctrl_t ctrl;
    logic        out_free;
    logic        advance;

    assign in_item.break_seen = rx.break_seen;
    assign in_item.data_byte  = rx.data_byte;

    // held item moves on when the result register has room
    assign advance = ctrl.valid && out_free;

    dmx_rx_in_stage u_in_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (rx.valid),
        .in_ready (rx.ready),
        .in_item  (in_item),
        .advance  (advance),
        .ctrl     (ctrl),
        .item     (held_item)
    );

    dmx_rx_fsm u_fsm (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .ctrl      (ctrl),
        .item      (held_item),
        .result    (result)
    );

    dmx_rx_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (ctrl.valid),
        .result    (result),
        .free      (out_free),
        .out_valid (slot.valid),
        .out_ready (slot.ready),
        .out_item  (out_item)
    );

    assign slot.capture_valid = out_item.capture_valid;
    assign slot.channel_index = out_item.channel_index;
    assign slot.channel_value = out_item.channel_value;
    assign slot.frame_done    = out_item.frame_done;
    assign slot.activity      = out_item.activity;

endmodule

`default_nettype wire

FILE: hdl/dmx_rx_in_stage.sv
// input register stage of the dmx slot receiver
`default_nettype none

module dmx_rx_in_stage (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire dmx_rx_pkg::char_t   in_item,
    input  wire logic                advance,
    output dmx_rx_pkg::stage_ctrl_t  ctrl,
    output dmx_rx_pkg::char_t        item
);
    import dmx_rx_pkg::*;

    logic  valid_reg;
    char_t item_reg;

    // take a new item when empty or when the held one moves on
    assign in_ready = !valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    // payload register
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg <= in_item;
        end
    end

    assign ctrl.valid   = valid_reg;
    assign ctrl.advance = advance;
    assign item         = item_reg;

endmodule

`default_nettype wire

FILE: hdl/dmx_rx_fsm.sv
// frame state machine: break, start code, address count and capture
`default_nettype none

module dmx_rx_fsm (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    cfg_we,
    input  wire logic [8:0]              cfg_wdata,
    input  wire dmx_rx_pkg::stage_ctrl_t ctrl,
    input  wire dmx_rx_pkg::char_t       item,
    output dmx_rx_pkg::slot_t            result
);
    import dmx_rx_pkg::*;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_BREAK,
        PH_COUNT,
        PH_CAPTURE
    } phase_t;

    localparam logic [CNT_W-1:0] LastCount = CNT_W'(NUM_CHANNELS);

    phase_t            phase_reg, phase_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [ADDR_W-1:0] start_reg;
    logic [CNT_W-1:0]  count_dec;
    logic [CNT_W-1:0]  count_inc;

    assign count_dec = count_reg - 1'b1;
    assign count_inc = count_reg + 1'b1;

    // next state and result for the held item
    always_comb
    begin
        phase_next = phase_reg;
        count_next = count_reg;
        result     = '0;
        if (item.break_seen)
        begin
            count_next = {1'b0, start_reg};
            phase_next = PH_BREAK;
        end
        else
        begin
            case (phase_reg)
                PH_BREAK:
                begin
                    phase_next = (item.data_byte == '0) ? PH_COUNT : PH_IDLE;
                end
                PH_COUNT:
                begin
                    result.activity = 1'b1;
                    count_next      = count_dec;
                    if (count_dec == '0)
                    begin
                        count_next           = CNT_W'(1);
                        result.capture_valid = 1'b1;
                        result.channel_value = item.data_byte;
                        phase_next           = PH_CAPTURE;
                    end
                end
                PH_CAPTURE:
                begin
                    result.capture_valid = 1'b1;
                    result.channel_index = count_reg[ADDR_W-1:0];
                    result.channel_value = item.data_byte;
                    count_next           = count_inc;
                    if (count_inc >= LastCount)
                    begin
                        result.frame_done = 1'b1;
                        phase_next        = PH_IDLE;
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    // state and start address register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            count_reg <= '0;
            start_reg <= ADDR_W'(1);
        end
        else
        begin
            if (cfg_we)
            begin
                start_reg <= cfg_wdata;
            end
            if (ctrl.valid && ctrl.advance)
            begin
                phase_reg <= phase_next;
                count_reg <= count_next;
            end
        end
    end

endmodule

`default_nettype wire

FILE: hdl/dmx_rx_out_stage.sv
// result register stage of the dmx slot receiver
`default_nettype none

module dmx_rx_out_stage (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              load,
    input  wire dmx_rx_pkg::slot_t result,
    output logic                   free,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output dmx_rx_pkg::slot_t      out_item
);
    import dmx_rx_pkg::*;

    logic  valid_reg;
    slot_t item_reg;

    // room for a result when empty or being taken this cycle
    assign free = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (free)
        begin
            valid_reg <= load;
        end
    end

    // payload register
    always_ff @(posedge clk)
    begin
        if (free && load)
        begin
            item_reg <= result;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

`default_nettype wire

FILE: hdl/dmx_rx_checker.sv
// port-level checks of the dmx slot receiver, bound to the top level
`default_nettype none

`include "dmx512_slot_receiver_assert.svh"

module dmx_rx_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic       capture_valid,
    input wire logic [8:0] channel_index,
    input wire logic [7:0] channel_value,
    input wire logic       frame_done,
    input wire logic       activity
);
    import dmx_rx_pkg::*;

    localparam logic [8:0] LastIndex = 9'(NUM_CHANNELS - 1);

    // frame done only comes with the last capture
    `DMX_ASSERT_IMPLY(a_done_is_last, out_valid && frame_done, capture_valid && channel_index == LastIndex, "frame done without last capture")

    // non-captured items carry zero index and value
    `DMX_ASSERT_IMPLY(a_idle_zero, out_valid && !capture_valid, channel_index == '0 && channel_value == '0, "nonzero payload without capture")

    // activity only with the first capture or no capture at all
    `DMX_ASSERT_IMPLY(a_activity_first, out_valid && activity && capture_valid, channel_index == '0 && !frame_done, "activity on a later slot")

    // a stalled result holds
    `DMX_ASSERT_NEXT(a_stall_hold, out_valid && !out_ready, out_valid && $stable(channel_index) && $stable(channel_value) && $stable(capture_valid), "result changed under stall")

endmodule

bind dmx512_slot_receiver dmx_rx_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (slot.valid),
    .out_ready     (slot.ready),
    .capture_valid (slot.capture_valid),
    .channel_index (slot.channel_index),
    .channel_value (slot.channel_value),
    .frame_done    (slot.frame_done),
    .activity      (slot.activity)
);

`default_nettype wire

FILE: tb/tb_dmx512_slot_receiver.sv
// testbench for the dmx slot receiver: frames in, predicted captured slots checked out
`timescale 1ns / 1ps

module tb_dmx512_slot_receiver;

    import dmx_rx_pkg::*;

    typedef enum logic [1:0] {
        RX_IDLE,
        RX_BREAK,
        RX_COUNT,
        RX_CAPTURE
    } rx_phase_t;

    // kinds of character sequences sent after a break
    typedef enum int {
        SEQ_FULL,
        SEQ_BAD_START,
        SEQ_CUT,
        SEQ_TRAILING
    } seq_kind_t;

    localparam int ITEMS_TARGET = 1150;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int LONG_HOLD = 60;
    localparam int END_CYCLES = 4;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [8:0] cfg_wdata;

    dmx_rx_char_if rx_ch ();
    dmx_rx_slot_if slot_ch ();

    dmx512_slot_receiver u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .rx        (rx_ch),
        .slot      (slot_ch)
    );

    // predicted frame state and start address
    rx_phase_t  model_phase;
    logic [9:0] model_count;
    logic [8:0] model_start;

    char_t char_queue[$];
    slot_t slot_expect[$];

    int  items_total;
    int  fail_count;
    int  send_gap;
    int  recv_gap;
    int  slots_checked;
    int  idle_cycles;
    bit  steady_flow;

    // clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // slot decoder: one result per received character
    function automatic slot_t predict_slot(input logic brk, input logic [7:0] b);
        slot_t r;
        r = '0;
        if (brk)
        begin
            model_count = {1'b0, model_start};
            model_phase = RX_BREAK;
        end
        else
        begin
            case (model_phase)
                RX_BREAK:
                begin
                    model_phase = (b == 8'h00) ? RX_COUNT : RX_IDLE;
                end
                RX_COUNT:
                begin
                    r.activity = 1'b1;
                    model_count = model_count - 10'd1;
                    if (model_count == 10'd0)
                    begin
                        model_count = 10'd1;
                        r.capture_valid = 1'b1;
                        r.channel_index = '0;
                        r.channel_value = b;
                        model_phase = RX_CAPTURE;
                    end
                end
                RX_CAPTURE:
                begin
                    r.capture_valid = 1'b1;
                    r.channel_index = model_count[8:0];
                    r.channel_value = b;
                    model_count = model_count + 10'd1;
                    if (model_count >= NUM_CHANNELS)
                    begin
                        r.frame_done = 1'b1;
                        model_phase = RX_IDLE;
                    end
                end
                default:
                begin
                end
            endcase
        end
        return r;
    endfunction

    // character sender
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_ch.valid <= 1'b0;
            rx_ch.break_seen <= 1'b0;
            rx_ch.data_byte <= '0;
            send_gap = 0;
        end
        else
        begin
            if (rx_ch.valid && rx_ch.ready)
                slot_expect.push_back(predict_slot(rx_ch.break_seen, rx_ch.data_byte));
            if (!rx_ch.valid || rx_ch.ready)
            begin
                if (send_gap != 0)
                begin
                    send_gap--;
                    rx_ch.valid <= 1'b0;
                end
                else if (char_queue.size() != 0)
                begin
                    rx_ch.break_seen <= char_queue[0].break_seen;
                    rx_ch.data_byte <= char_queue[0].data_byte;
                    rx_ch.valid <= 1'b1;
                    void'(char_queue.pop_front());
                    send_gap = steady_flow ? 0 : $urandom_range(0, 3);
                end
                else
                begin
                    rx_ch.valid <= 1'b0;
                end
            end
        end
    end

    // slot receiver and checker
    always @(posedge clk or negedge rst_n)
    begin
        slot_t want;
        if (!rst_n)
        begin
            slot_ch.ready <= 1'b0;
            recv_gap = 0;
        end
        else
        begin
            if (slot_ch.valid && slot_ch.ready)
            begin
                if (slot_expect.size() == 0)
                begin
                    $error("slot item with nothing expected");
                    fail_count++;
                end
                else
                begin
                    want = slot_expect.pop_front();
                    if (slot_ch.capture_valid !== want.capture_valid)
                    begin
                        $error("capture_valid: expected %0d, got %0d",
                               want.capture_valid, slot_ch.capture_valid);
                        fail_count++;
                    end
                    if (slot_ch.channel_index !== want.channel_index)
                    begin
                        $error("channel_index: expected %0d, got %0d",
                               want.channel_index, slot_ch.channel_index);
                        fail_count++;
                    end
                    if (slot_ch.channel_value !== want.channel_value)
                    begin
                        $error("channel_value: expected %0d, got %0d",
                               want.channel_value, slot_ch.channel_value);
                        fail_count++;
                    end
                    if (slot_ch.frame_done !== want.frame_done)
                    begin
                        $error("frame_done: expected %0d, got %0d",
                               want.frame_done, slot_ch.frame_done);
                        fail_count++;
                    end
                    if (slot_ch.activity !== want.activity)
                    begin
                        $error("activity: expected %0d, got %0d",
                               want.activity, slot_ch.activity);
                        fail_count++;
                    end
                end
                slots_checked++;
                recv_gap = steady_flow ? 0 : $urandom_range(0, 3);
                // long hold so the block backs up into its input
                if (slots_checked == 150 || slots_checked == 650)
                    recv_gap = LONG_HOLD;
            end
            if (recv_gap != 0)
            begin
                recv_gap--;
                slot_ch.ready <= 1'b0;
            end
            else
            begin
                slot_ch.ready <= 1'b1;
            end
        end
    end

    // watchdog on cycles without any accepted item
    always @(posedge clk)
    begin
        if (rst_n && !(rx_ch.valid && rx_ch.ready) && !(slot_ch.valid && slot_ch.ready))
        begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Some tests failed");
                $finish;
            end
        end
        else
        begin
            idle_cycles = 0;
        end
    end

    task automatic queue_char(input logic brk, input logic [7:0] b);
        char_t c;
        c.break_seen = brk;
        c.data_byte = b;
        char_queue.push_back(c);
        items_total++;
    endtask

    // wait until every item is sent and every slot result has come back
    task automatic wait_drained();
        do
            @(negedge clk);
        while (char_queue.size() != 0 || rx_ch.valid || slot_expect.size() != 0);
    endtask

    task automatic set_start_address(input logic [8:0] addr);
        wait_drained();
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= addr;
        model_start = addr;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
        steady_flow = ($urandom_range(0, 3) == 0);
    endtask

    // break followed by a well-formed or broken frame
    task automatic queue_sequence(input seq_kind_t kind);
        int last_slot;
        int len;
        last_slot = int'(model_start) + NUM_CHANNELS - 1;
        queue_char(1'b1, 8'($urandom));
        if (kind == SEQ_BAD_START)
        begin
            queue_char(1'b0, 8'($urandom_range(1, 255)));
            repeat ($urandom_range(0, 2)) queue_char(1'b0, 8'($urandom));
        end
        else
        begin
            queue_char(1'b0, 8'h00);
            len = (kind == SEQ_CUT) ? $urandom_range(0, last_slot - 1) : last_slot;
            repeat (len) queue_char(1'b0, 8'($urandom));
            if (kind == SEQ_TRAILING)
                repeat ($urandom_range(1, 3)) queue_char(1'b0, 8'($urandom));
        end
    endtask

    initial
    begin
        int pick;
        seq_kind_t kind;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        model_phase = RX_IDLE;
        model_count = '0;
        model_start = 9'd1;
        items_total = 0;
        fail_count = 0;
        slots_checked = 0;
        idle_cycles = 0;
        steady_flow = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // idle bytes are ignored
        queue_char(1'b0, 8'hFF);
        queue_char(1'b0, 8'h00);
        // non-zero start code returns to idle, break byte value ignored
        queue_char(1'b1, 8'hFF);
        queue_char(1'b0, 8'h01);
        queue_char(1'b0, 8'h55);
        // full frame at the reset start address, extreme values
        queue_char(1'b1, 8'h00);
        queue_char(1'b0, 8'h00);
        queue_char(1'b0, 8'h00);
        queue_char(1'b0, 8'hFF);
        queue_char(1'b0, 8'h80);
        queue_char(1'b0, 8'h01);
        queue_char(1'b0, 8'hAA);
        queue_char(1'b0, 8'h55);
        queue_char(1'b0, 8'h7F);
        queue_char(1'b0, 8'hFE);
        queue_char(1'b0, 8'h33);
        // break in the middle of capture re-arms start code checking
        queue_char(1'b1, 8'hA5);
        queue_char(1'b0, 8'h00);
        queue_char(1'b0, 8'h11);
        queue_char(1'b0, 8'h22);
        queue_char(1'b0, 8'h33);
        queue_char(1'b1, 8'h5A);
        queue_char(1'b0, 8'hFF);

        // highest start address, one full frame
        set_start_address(9'd511);
        queue_sequence(SEQ_FULL);

        // start address zero: counter wraps, only activity until the next break
        set_start_address(9'd0);
        queue_char(1'b1, 8'h3C);
        queue_char(1'b0, 8'h00);
        repeat (30) queue_char(1'b0, 8'($urandom));
        queue_char(1'b1, 8'hC3);
        queue_char(1'b0, 8'h00);
        repeat (4) queue_char(1'b0, 8'($urandom));

        set_start_address(9'd2);
        queue_sequence(SEQ_FULL);
        queue_sequence(SEQ_TRAILING);
        set_start_address(9'd1);
        queue_sequence(SEQ_FULL);
        queue_sequence(SEQ_CUT);

        // random frames, mostly well formed, at mostly small start addresses
        while (items_total < ITEMS_TARGET)
        begin
            if ($urandom_range(0, 7) == 0)
                set_start_address(9'($urandom_range(13, 60)));
            else
                set_start_address(9'($urandom_range(1, 12)));
            repeat ($urandom_range(3, 6))
            begin
                pick = $urandom_range(0, 9);
                if (pick == 0)
                    kind = SEQ_BAD_START;
                else if (pick == 1)
                    kind = SEQ_CUT;
                else if (pick == 2)
                    kind = SEQ_TRAILING;
                else
                    kind = SEQ_FULL;
                queue_sequence(kind);
            end
        end

        wait_drained();
        repeat (END_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/dmx_rx_pkg.sv
hdl/dmx_rx_if.sv
hdl/dmx_rx_in_stage.sv
hdl/dmx_rx_fsm.sv
hdl/dmx_rx_out_stage.sv
hdl/dmx512_slot_receiver.sv
hdl/dmx_rx_checker.sv
tb/tb_dmx512_slot_receiver.sv
